// File: rtl/encoder_edge_speed_meter_defines.svh
// Assertion macros for the encoder edge speed meter.
`ifndef ENCODER_EDGE_SPEED_METER_DEFINES_SVH
`define ENCODER_EDGE_SPEED_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EESM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define EESM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EESM_ASSERT(name, prop, msg)
`define EESM_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/eesm_pkg.sv
package eesm_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [31:0] SPEED_NUM_RESET = 32'd12000000;
  localparam logic [31:0] OUT_MAX = 32'hffffffff;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic index_pin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] edge_total;
    logic        forward;
    logic [31:0] period_ticks;
    logic [31:0] speed_rpm;
  } out_item_t;

  typedef struct packed {
    logic [31:0] edge_total;
    logic        forward;
    logic [31:0] period_ticks;
  } edge_rec_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } back_status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

// File: rtl/eesm_queue.sv
module eesm_queue
  import eesm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  edge_rec_t push_data,
  output logic      space,
  input  logic      pop,
  output logic      valid,
  output edge_rec_t pop_data
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);

  edge_rec_t         slots [DEPTH];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CountW-1:0] count;

  assign space    = (count != CountW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(DEPTH - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(DEPTH - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

endmodule

// File: rtl/eesm_front.sv
module eesm_front
  import eesm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_item_t  item,
  output logic      push,
  output edge_rec_t push_data
);

  localparam int WideW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic                   last_a;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [31:0]            edge_counter;
  logic [COUNT_WIDTH-1:0] ticks_inc;
  logic [WideW-1:0]       ticks_wide;
  logic [31:0]            edge_counter_next;
  logic                   is_edge;

  assign is_edge    = (item.enc_a != last_a);
  assign ticks_inc  = (ticks == '1) ? ticks : ticks + COUNT_WIDTH'(1);
  assign ticks_wide = WideW'(ticks_inc);
  assign edge_counter_next = item.index_pin ? '0 : edge_counter + 32'd1;

  assign push                   = accept && is_edge;
  assign push_data.edge_total   = edge_counter_next;
  assign push_data.forward      = item.enc_b;
  assign push_data.period_ticks = (ticks_wide > WideW'(OUT_MAX)) ? OUT_MAX : ticks_wide[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_a       <= 1'b0;
      ticks        <= '0;
      edge_counter <= '0;
    end else if (accept) begin
      last_a <= item.enc_a;
      if (is_edge) begin
        ticks        <= '0;
        edge_counter <= edge_counter_next;
      end else begin
        ticks <= ticks_inc;
      end
    end
  end

endmodule

// File: rtl/eesm_back.sv
module eesm_back
  import eesm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         q_valid,
  input  edge_rec_t    q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_data,
  output back_status_t status
);

  localparam int StepW = $clog2(DIV_STEPS);

  div_state_t       state;
  div_state_t       state_next;
  logic [31:0]      speed_numerator;
  edge_rec_t        job;
  logic [31:0]      quot;
  logic [31:0]      rem;
  logic [StepW-1:0] step;
  logic [32:0]      trial;
  logic [32:0]      shifted;
  logic             last_step;
  logic             load_out;

  assign shifted   = {rem, quot[31]};
  assign trial     = shifted - {1'b0, job.period_ticks};
  assign last_step = (step == StepW'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (q_valid) state_next = DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_DONE;
      DIV_DONE: if (!out_valid || out_ready) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      DIV_IDLE: q_pop = q_valid;
      DIV_RUN:  ;
      DIV_DONE: load_out = !out_valid || out_ready;
      default:  ;
    endcase
  end

  assign status.busy     = (state != DIV_IDLE);
  assign status.out_load = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= DIV_IDLE;
      speed_numerator <= SPEED_NUM_RESET;
      out_valid       <= 1'b0;
      step            <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        speed_numerator <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        step <= '0;
      end else if (state == DIV_RUN) begin
        step <= step + StepW'(1);
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_data;
      quot <= speed_numerator;
      rem  <= '0;
    end else if (state == DIV_RUN) begin
      if (!trial[32]) begin
        rem  <= trial[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= shifted[31:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.edge_total   <= job.edge_total;
      out_data.forward      <= job.forward;
      out_data.period_ticks <= job.period_ticks;
      out_data.speed_rpm    <= quot;
    end
  end

endmodule

// File: rtl/encoder_edge_speed_meter.sv
// Encoder edge speed meter.
// in_valid/in_ready/in_data: one sample of A, B and index per transfer,
// normally one every clock. A change of A against the previous sample
// produces one result: edge count, direction, period and rpm.
// out_valid/out_ready/out_data: one transfer per A edge, in order.
// cfg_we/cfg_wdata: write speed_numerator (reset 12000000); the user must
// write it only while idle, which the block does not enforce. Samples are
// taken one per cycle while the edge queue has room. Each edge is queued,
// then a bit-serial divider loads it, forms the quotient one bit per cycle
// and places the result in the output register. The divider handles one
// edge at a time, so later edges wait in the queue; samples wait only
// while the edge queue is full.
// When the receiver stalls, the divider holds its result, the queue fills
// and in_ready drops once the queue is full.
// Reset (rst, synchronous) clears the tick counter, edge count, last A
// level, queue and output valid, and restores the numerator.
module encoder_edge_speed_meter
  import eesm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

`include "encoder_edge_speed_meter_defines.svh"

  logic         push;
  edge_rec_t    push_data;
  logic         q_space;
  logic         q_pop;
  logic         q_valid;
  edge_rec_t    q_data;
  back_status_t back_status;

  assign in_ready = q_space;

  eesm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_valid && in_ready),
    .item     (in_data),
    .push     (push),
    .push_data(push_data)
  );

  eesm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .space    (q_space),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_data)
  );

  eesm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .status   (back_status)
  );

  `EESM_ASSERT(a_pop_has_data, !q_pop || q_valid, "pop from empty edge queue")
  `EESM_ASSERT_NEXT(a_pop_starts_div, q_pop, back_status.busy, "divider idle after pop")
  `EESM_ASSERT_NEXT(a_load_sets_valid, back_status.out_load, out_valid, "result not presented")

endmodule
